/* design/first_fit_heap_allocator_core_defines.svh */
// assertion macros for the first-fit heap allocator
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH
`ifndef SYNTH
`define FFHA_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define FFHA_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define FFHA_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define FFHA_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

/* design/ffha_pkg.sv */
// shared types and constants of the first-fit heap allocator
`default_nettype none
package ffha_pkg;
    localparam int HEAP_GRANULES_DEF = 8192;
    localparam int MAX_SEGMENTS_DEF  = 32;
    localparam int HEADER_BYTES_DEF  = 16;
    localparam int ALIGN_BYTES_DEF   = 8;
    localparam int MIN_UNITS         = 8;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NOSP = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_HEAP_UNITS = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] req;
        logic [47:0] addr;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] payload_address;
        logic [16:0] remaining_bytes;
    } t_rsp;
endpackage
`default_nettype wire

/* design/ffha_req_if.sv */
// request channel interface
`default_nettype none
interface ffha_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] request_bytes;
    logic [47:0] block_address;
    modport source (output valid, command, request_bytes, block_address, input ready);
    modport sink (input valid, command, request_bytes, block_address, output ready);
endinterface
`default_nettype wire

/* design/ffha_rsp_if.sv */
// result channel interface
`default_nettype none
interface ffha_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [47:0] payload_address;
    logic [16:0] remaining_bytes;
    modport source (output valid, status, payload_address, remaining_bytes, input ready);
    modport sink (input valid, status, payload_address, remaining_bytes, output ready);
endinterface
`default_nettype wire

/* design/first_fit_heap_allocator_core.sv */
// first-fit heap allocator with coalescing: top level
// requests arrive on s_req (command, request_bytes, block_address) and each
// gives exactly one item on m_rsp (status, payload_address, remaining_bytes).
// a two-item queue in front takes requests while the back end works.
// the back end sequencer walks the free segment table one entry a cycle:
// an allocate scans for the first segment that fits and shifts the table
// down over that entry when the segment is used up; a free walks to its
// place, merges with adjacent segments and shifts the table when a
// segment is removed or inserted.
// after reset the first request forms the heap from heap_base and
// heap_units and clears the allocated marks, one entry a cycle, for all
// HEAP_GRANULES entries (8192 by default) before the first result.
// later register writes have no effect until the next reset.
// the result register holds its item while m_rsp.ready is low; the back
// end then waits and the front queue fills and drops s_req.ready.
`default_nettype none
module first_fit_heap_allocator_core
    import ffha_pkg::*;
#(
    parameter int HEAP_GRANULES = ffha_pkg::HEAP_GRANULES_DEF,
    parameter int MAX_SEGMENTS  = ffha_pkg::MAX_SEGMENTS_DEF,
    parameter int HEADER_BYTES  = ffha_pkg::HEADER_BYTES_DEF,
    parameter int ALIGN_BYTES   = ffha_pkg::ALIGN_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [47:0] i_cfg_wdata,
    ffha_req_if.sink         s_req,
    ffha_rsp_if.source       m_rsp
);
    `include "first_fit_heap_allocator_core_defines.svh"
    logic [47:0] r_heap_base;
    logic [13:0] r_heap_units;
    logic        q_valid, take, busy;
    t_req        q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= '0;
            r_heap_units <= 14'd8192;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HEAP_BASE:  r_heap_base <= i_cfg_wdata;
                CFG_HEAP_UNITS: r_heap_units <= i_cfg_wdata[13:0];
                default: ;
            endcase
        end
    end

    ffha_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_req(s_req),
        .o_valid(q_valid), .o_item(q_item), .i_take(take));

    ffha_back #(
        .HEAP_GRANULES(HEAP_GRANULES), .MAX_SEGMENTS(MAX_SEGMENTS),
        .HEADER_BYTES(HEADER_BYTES), .ALIGN_BYTES(ALIGN_BYTES)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_heap_base(r_heap_base),
        .i_heap_units(r_heap_units), .i_valid(q_valid), .i_item(q_item),
        .o_take(take), .o_busy(busy), .m_rsp(m_rsp));

    `FFHA_ASSERT_IMP(a_take_valid, i_clk, i_rst_n, take, q_valid)
    `FFHA_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, take, busy)
    `FFHA_ASSERT_IMP(a_stall_hold, i_clk, i_rst_n, m_rsp.valid && !m_rsp.ready, busy)
endmodule
`default_nettype wire

/* design/ffha_ram.sv */
// generic single-port ram with registered read
`default_nettype none
module ffha_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

/* design/ffha_front.sv */
// front end: request queue of two items
`default_nettype none
module ffha_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    ffha_req_if.sink                 s_req,
    output logic                     o_valid,
    output ffha_pkg::t_req           o_item,
    input  wire logic                i_take
);
    import ffha_pkg::*;
    t_req r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign s_req.ready = (r_cnt != 2'd2);
    assign push = s_req.valid && s_req.ready;
    assign pop  = i_take && (r_cnt != 2'd0);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{s_req.command, s_req.request_bytes, s_req.block_address};
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

/* design/ffha_back.sv */
// back end: free segment table scan, split, merge and shift sequencer
`default_nettype none
module ffha_back #(
    parameter int HEAP_GRANULES = ffha_pkg::HEAP_GRANULES_DEF,
    parameter int MAX_SEGMENTS  = ffha_pkg::MAX_SEGMENTS_DEF,
    parameter int HEADER_BYTES  = ffha_pkg::HEADER_BYTES_DEF,
    parameter int ALIGN_BYTES   = ffha_pkg::ALIGN_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [47:0]   i_heap_base,
    input  wire logic [13:0]   i_heap_units,
    input  wire logic          i_valid,
    input  wire ffha_pkg::t_req i_item,
    output logic               o_take,
    output logic               o_busy,
    ffha_rsp_if.source         m_rsp
);
    import ffha_pkg::*;
    localparam int HG   = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int GW   = $clog2(HEAP_GRANULES + 1);
    localparam int AW   = $clog2(HEAP_GRANULES);
    localparam int SW   = $clog2(MAX_SEGMENTS);
    localparam int CW   = $clog2(MAX_SEGMENTS + 1);
    localparam int LB   = $clog2(ALIGN_BYTES);
    localparam int MINU = (MIN_UNITS > 2 * HG) ? MIN_UNITS : 2 * HG;
    localparam int MW   = 28;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_FORM  = 11'b00000000010,
        S_CLEAR = 11'b00000000100,
        S_DEC   = 11'b00000001000,
        S_SCAN  = 11'b00000010000,
        S_ALLOC = 11'b00000100000,
        S_FRD   = 11'b00001000000,
        S_FREE  = 11'b00010000000,
        S_SHL   = 11'b00100000000,
        S_SHR   = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    t_state r_st, n_st;
    logic [GW-1:0] r_start [MAX_SEGMENTS];
    logic [GW-1:0] r_size  [MAX_SEGMENTS];
    logic [CW-1:0] r_cnt;
    logic [MW-1:0] r_left;
    logic          r_formed;
    logic [47:0]   r_base;
    logic [GW-1:0] r_units;
    logic [AW-1:0] r_clr;
    logic [SW:0]   r_p;
    logic [SW:0]   r_k;
    t_req          r_item;
    logic [GW-1:0] r_n;
    logic [GW-1:0] r_g;
    logic [1:0]    r_status;
    logic [47:0]   r_paddr;
    logic          r_ovalid;
    logic [1:0]    r_ostatus;
    logic [47:0]   r_opaddr;
    logic [16:0]   r_oleft;

    logic          mk_we, mk_rd;
    logic [AW-1:0] mk_addr;
    logic          bu_we;
    logic [GW-1:0] bu_wdata;
    logic [GW-1:0] bu_rd;
    logic [SW-1:0] ps, pm1;
    logic [GW-1:0] cur_start, cur_size, prv_start, prv_size;
    logic          mp, mn;
    logic [GW-1:0] u_sat;
    logic [47:0]   off_raw;

    ffha_ram #(.WIDTH(1), .DEPTH(HEAP_GRANULES)) u_mark (
        .i_clk(i_clk), .i_we(mk_we), .i_addr(mk_addr),
        .i_wdata(r_st == S_ALLOC), .o_rdata(mk_rd));
    ffha_ram #(.WIDTH(GW), .DEPTH(HEAP_GRANULES)) u_units (
        .i_clk(i_clk), .i_we(bu_we), .i_addr(r_g[AW-1:0]),
        .i_wdata(bu_wdata), .o_rdata(bu_rd));

    assign ps  = r_p[SW-1:0];
    assign pm1 = ps - 1'b1;
    assign cur_start = r_start[ps];
    assign cur_size  = r_size[ps];
    assign prv_start = r_start[pm1];
    assign prv_size  = r_size[pm1];
    assign mp = (r_p != '0) && (prv_start + prv_size == r_g);
    assign mn = ({1'b0, r_p} < {1'b0, r_cnt}) && (r_g + bu_rd == cur_start);
    assign off_raw = r_item.addr - r_base;

    always_comb begin
        if ({18'd0, i_heap_units} < MINU) u_sat = GW'(MINU);
        else if ({18'd0, i_heap_units} > HEAP_GRANULES) u_sat = GW'(HEAP_GRANULES);
        else u_sat = GW'(i_heap_units);
    end

    assign mk_addr = (r_st == S_CLEAR) ? r_clr : r_g[AW-1:0];
    assign mk_we   = (r_st == S_CLEAR) || (r_st == S_ALLOC)
                     || (r_st == S_FREE && r_status == ST_OK && (mp || mn
                        || r_cnt < CW'(MAX_SEGMENTS)));
    assign bu_we   = (r_st == S_ALLOC);
    // a segment that is used up goes to the block whole
    assign bu_wdata = (cur_size - r_n >= GW'(HG + 1)) ? r_n : cur_size;

    assign o_take = (r_st == S_IDLE) && i_valid;
    assign o_busy = (r_st != S_IDLE) || r_ovalid;
    assign m_rsp.valid = r_ovalid;
    assign m_rsp.status = r_ostatus;
    assign m_rsp.payload_address = r_opaddr;
    assign m_rsp.remaining_bytes = r_oleft;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:  if (i_valid) n_st = r_formed ? S_DEC : S_FORM;
            S_FORM:  n_st = S_CLEAR;
            S_CLEAR: if (r_clr == AW'(HEAP_GRANULES - 1)) n_st = S_DEC;
            S_DEC:   n_st = (r_item.cmd == CMD_ALLOC) ? S_SCAN : S_FRD;
            S_SCAN: begin
                if ({1'b0, r_p} >= {1'b0, r_cnt}) n_st = S_DONE;
                else if (cur_size >= r_n) n_st = S_ALLOC;
            end
            S_ALLOC: n_st = (cur_size - r_n >= GW'(HG + 1)) ? S_DONE : S_SHL;
            S_FRD: begin
                if (r_status != ST_OK || r_item.addr == '0) n_st = S_DONE;
                else if ({1'b0, r_p} < {1'b0, r_cnt} && cur_start < r_g) n_st = S_FRD;
                else n_st = S_FREE;
            end
            S_FREE: begin
                if (!mk_rd) n_st = S_DONE;
                else if (mp && mn) n_st = S_SHL;
                else if (mp || mn) n_st = S_DONE;
                else if (r_cnt >= CW'(MAX_SEGMENTS)) n_st = S_DONE;
                else n_st = S_SHR;
            end
            S_SHL: if ({1'b0, r_k} + 2 >= {1'b0, r_cnt} + 1) n_st = S_DONE;
            S_SHR: if (r_k <= r_p) n_st = S_DONE;
            S_DONE: if (!r_ovalid || m_rsp.ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_cnt <= '0;
            r_left <= '0;
            r_formed <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_ovalid && m_rsp.ready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    r_item <= i_item;
                    r_p <= '0;
                    r_status <= ST_OK;
                    r_paddr <= '0;
                end
                S_FORM: begin
                    r_base <= i_heap_base;
                    r_units <= u_sat;
                    r_cnt <= CW'(1);
                    r_start[0] <= '0;
                    r_size[0] <= u_sat - GW'(HG);
                    r_left <= MW'(u_sat - GW'(HG)) << LB;
                    r_formed <= 1'b1;
                    r_clr <= '0;
                end
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_DEC: begin
                    r_n <= GW'((18'(HG * ALIGN_BYTES) + 18'(r_item.req)
                           + 18'(ALIGN_BYTES - 1)) >> LB);
                    r_g <= GW'((off_raw - 48'(HG * ALIGN_BYTES)) >> LB);
                    if (r_item.cmd == CMD_FREE && r_item.addr != '0) begin
                        if (off_raw < 48'(HG * ALIGN_BYTES)
                            || off_raw[LB-1:0] != '0
                            || ((off_raw - 48'(HG * ALIGN_BYTES)) >> LB)
                               >= 48'(r_units - GW'(HG)))
                            r_status <= ST_BAD;
                    end
                end
                S_SCAN: begin
                    if ({1'b0, r_p} >= {1'b0, r_cnt}) r_status <= ST_NOSP;
                    else if (cur_size >= r_n) r_g <= cur_start;
                    else r_p <= r_p + 1'b1;
                end
                S_ALLOC: begin
                    r_paddr <= r_base + {cur_start + GW'(HG), LB'(0)};
                    if (cur_size - r_n >= GW'(HG + 1)) begin
                        r_start[ps] <= cur_start + r_n;
                        r_size[ps] <= cur_size - r_n;
                        r_left <= r_left - (MW'(r_n) << LB);
                    end else begin
                        r_n <= cur_size;
                        r_left <= r_left - (MW'(cur_size) << LB);
                        r_k <= r_p;
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_FRD: begin
                    if ({1'b0, r_p} < {1'b0, r_cnt} && cur_start < r_g)
                        r_p <= r_p + 1'b1;
                end
                S_FREE: begin
                    if (!mk_rd) r_status <= ST_BAD;
                    else if (mp && mn) begin
                        r_size[pm1] <= prv_size + bu_rd + cur_size;
                        r_k <= r_p;
                        r_cnt <= r_cnt - 1'b1;
                        r_left <= r_left + (MW'(bu_rd) << LB);
                    end else if (mp) begin
                        r_size[pm1] <= prv_size + bu_rd;
                        r_left <= r_left + (MW'(bu_rd) << LB);
                    end else if (mn) begin
                        r_start[ps] <= r_g;
                        r_size[ps] <= cur_size + bu_rd;
                        r_left <= r_left + (MW'(bu_rd) << LB);
                    end else if (r_cnt >= CW'(MAX_SEGMENTS)) r_status <= ST_FULL;
                    else begin
                        r_k <= (SW + 1)'(r_cnt);
                        r_n <= bu_rd;
                        r_cnt <= r_cnt + 1'b1;
                        r_left <= r_left + (MW'(bu_rd) << LB);
                    end
                end
                S_SHL: begin
                    // r_cnt is already the new count here
                    if ({1'b0, r_k} + 1 <= {1'b0, r_cnt}) begin
                        r_start[r_k[SW-1:0]] <= r_start[SW'(r_k + 1'b1)];
                        r_size[r_k[SW-1:0]] <= r_size[SW'(r_k + 1'b1)];
                    end
                    r_k <= r_k + 1'b1;
                end
                S_SHR: begin
                    if (r_k > r_p) begin
                        r_start[r_k[SW-1:0]] <= r_start[SW'(r_k - 1'b1)];
                        r_size[r_k[SW-1:0]] <= r_size[SW'(r_k - 1'b1)];
                        r_k <= r_k - 1'b1;
                    end else begin
                        r_start[ps] <= r_g;
                        r_size[ps] <= r_n;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || m_rsp.ready) begin
                        r_ovalid <= 1'b1;
                        r_ostatus <= r_status;
                        r_opaddr <= (r_item.cmd == CMD_ALLOC && r_status == ST_OK)
                                    ? r_paddr : 48'd0;
                        r_oleft <= r_left[16:0];
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
